// ----- hw/rtl/prm_pkg.sv -----
// Shared constants, codes and types for the pulse rate meter.
package prm_pkg;

  // Field widths
  localparam int TIME_BITS   = 40;
  localparam int SAMPLE_BITS = 12;
  localparam int BEAT_BITS   = 8;
  localparam int TMO_BITS    = 16;
  localparam int BPM_BITS    = 8;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = SAMPLE_BITS + TIME_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 + BPM_BITS;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Time scale constants
  localparam longint US_PER_MIN = 60000000;
  localparam int     US_PER_MS  = 1000;

  // Numerator beats_needed * 60e6 fits in 34 bits; the timeout limit in 26 bits
  localparam int NUM_BITS = 34;
  localparam int LIM_BITS = 26;

  // Divisor is the duration pre-shifted by the quotient width
  localparam int D_BITS    = TIME_BITS + BPM_BITS;
  localparam int STEP_BITS = 4;
  localparam int CNT_BITS  = $clog2(TIME_BITS);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_BEATS_NEEDED = 2'd1,
    REG_TMO_MS       = 2'd2,
    REG_LED_ENABLE   = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SERIAL = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

// ----- hw/rtl/pulse_rate_meter.sv -----
// Pulse rate meter: edge detection, bit-serial timing and a serial rate divider.

// Each accepted sample produces exactly one result beat. A sample seen while no
// measurement runs and without the start flag skips the serial pass and goes
// straight to the finish state. A measuring sample runs a bit-serial pass over
// the 40-bit timestamp, one bit per cycle, that forms the time since the last
// pulse start and the time since the first rise, and compares the first
// against the timeout limit in microseconds.
// The sample that completes a measurement adds a restoring divider of one
// quotient bit per cycle. A finished result waits in the output register
// while the next sample is already being processed. Configuration is written
// through cfg_we/cfg_index/cfg_data and must only change while no sample is
// in flight.
module pulse_rate_meter (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [prm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prm_pkg::CFG_W-1:0]        cfg_data,
  // Sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: sample[11:0], time_us[51:12], zero padding above
  input  logic [prm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: start_req
  input  logic                             s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: led[0], active[1], done_res[2], timed_out[3], bpm[11:4], zero above
  output logic [prm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int TB = prm_pkg::TIME_BITS;

  // Configuration registers
  logic [prm_pkg::SAMPLE_BITS-1:0] threshold;
  logic [prm_pkg::BEAT_BITS-1:0]   beats_needed;
  logic [prm_pkg::TMO_BITS-1:0]    tmo_ms;
  logic                            led_enable;

  // Measurement state
  logic                            measuring;
  logic                            in_pulse;
  logic [prm_pkg::BEAT_BITS-1:0]   beat_count;
  logic [TB-1:0]                   first_rise_time;
  logic                            first_rise_seen;
  logic [TB-1:0]                   timeout_reference;
  logic                            led_level;

  // Sequencer and serial datapath
  prm_pkg::state_t                 state;
  logic [prm_pkg::CNT_BITS-1:0]    bit_cnt;
  logic [TB-1:0]                   now_sr;
  logic [TB-1:0]                   lim_sr;
  logic                            brw_el;
  logic                            brw_du;
  logic                            gt;
  logic                            nz;

  // Divider
  logic [prm_pkg::NUM_BITS-1:0]    rem;
  logic [prm_pkg::D_BITS-1:0]      dvs;
  logic [prm_pkg::STEP_BITS-1:0]   step;
  logic [prm_pkg::BPM_BITS-1:0]    quo;

  // Result under construction and the output register
  logic                            r_active;
  logic                            r_done;
  logic                            r_tout;
  logic [prm_pkg::BPM_BITS-1:0]    r_bpm;
  logic                            o_led;
  logic                            o_active;
  logic                            o_done;
  logic                            o_tout;
  logic [prm_pkg::BPM_BITS-1:0]    o_bpm;

  // Input field unpacking
  logic [prm_pkg::SAMPLE_BITS-1:0] in_sample;
  logic [TB-1:0]                   in_time;
  logic                            in_accept;

  assign in_sample = s_axis_tdata[prm_pkg::SAMPLE_BITS-1:0];
  assign in_time   = s_axis_tdata[prm_pkg::IN_FIELDS_W-1:prm_pkg::SAMPLE_BITS];
  assign s_axis_tready = (state == prm_pkg::S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Start handling and edge detection applied at the accepting edge
  logic                            meas_acc;
  logic                            pulse_acc;
  logic [prm_pkg::BEAT_BITS-1:0]   count_acc;
  logic [TB-1:0]                   rise_acc;
  logic                            seen_acc;
  logic [TB-1:0]                   tref_acc;
  logic                            led_acc;
  logic                            hit;

  always_comb begin
    meas_acc  = s_axis_tuser || measuring;
    pulse_acc = s_axis_tuser ? 1'b0 : in_pulse;
    count_acc = s_axis_tuser ? '0 : beat_count;
    rise_acc  = s_axis_tuser ? '0 : first_rise_time;
    seen_acc  = s_axis_tuser ? 1'b0 : first_rise_seen;
    tref_acc  = s_axis_tuser ? in_time : timeout_reference;
    led_acc   = s_axis_tuser ? 1'b0 : led_level;
    hit       = (in_sample >= threshold);
    if (meas_acc) begin
      if (!pulse_acc && hit) begin
        led_acc = led_enable;
        if (!seen_acc) begin
          rise_acc = in_time;
          seen_acc = 1'b1;
        end
        pulse_acc = 1'b1;
        tref_acc  = in_time;
      end else if (pulse_acc && !hit) begin
        led_acc   = 1'b0;
        pulse_acc = 1'b0;
        if (count_acc != '1) begin
          count_acc = count_acc + 1'b1;
        end
      end
    end
  end

  // One bit of both subtractions and of the timeout compare, LSB first
  logic el_bit;
  logic du_bit;
  logic brw_el_next;
  logic brw_du_next;
  logic gt_next;
  logic nz_next;

  always_comb begin
    el_bit      = now_sr[0] ^ timeout_reference[0] ^ brw_el;
    brw_el_next = (~now_sr[0] & timeout_reference[0]) |
                  (~(now_sr[0] ^ timeout_reference[0]) & brw_el);
    du_bit      = now_sr[0] ^ first_rise_time[0] ^ brw_du;
    brw_du_next = (~now_sr[0] & first_rise_time[0]) |
                  (~(now_sr[0] ^ first_rise_time[0]) & brw_du);
    gt_next     = (el_bit & ~lim_sr[0]) | (gt & ~(el_bit ^ lim_sr[0]));
    nz_next     = nz | du_bit;
  end

  // Constant-factor products: timeout limit and rate numerator
  logic [prm_pkg::LIM_BITS-1:0] lim_full;
  logic [prm_pkg::NUM_BITS-1:0] num_full;

  assign lim_full = prm_pkg::LIM_BITS'(tmo_ms) *
                    prm_pkg::LIM_BITS'(prm_pkg::US_PER_MS);
  assign num_full = prm_pkg::NUM_BITS'(beats_needed) *
                    prm_pkg::NUM_BITS'(prm_pkg::US_PER_MIN);

  // Divider trial subtraction
  logic div_ge;

  assign div_ge = (prm_pkg::D_BITS'(rem) >= dvs);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= prm_pkg::SAMPLE_BITS'(2048);
      beats_needed <= prm_pkg::BEAT_BITS'(10);
      tmo_ms       <= prm_pkg::TMO_BITS'(5000);
      led_enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (prm_pkg::reg_idx_t'(cfg_index))
        prm_pkg::REG_THRESHOLD:    threshold    <= cfg_data[prm_pkg::SAMPLE_BITS-1:0];
        prm_pkg::REG_BEATS_NEEDED: beats_needed <= cfg_data[prm_pkg::BEAT_BITS-1:0];
        prm_pkg::REG_TMO_MS:       tmo_ms       <= cfg_data[prm_pkg::TMO_BITS-1:0];
        prm_pkg::REG_LED_ENABLE:   led_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer with measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= prm_pkg::S_IDLE;
      measuring         <= 1'b0;
      in_pulse          <= 1'b0;
      beat_count        <= '0;
      first_rise_time   <= '0;
      first_rise_seen   <= 1'b0;
      timeout_reference <= '0;
      led_level         <= 1'b0;
      bit_cnt           <= '0;
      step              <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      // The finish state reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && state != prm_pkg::S_FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        prm_pkg::S_IDLE: begin
          if (in_accept) begin
            measuring         <= meas_acc;
            in_pulse          <= pulse_acc;
            beat_count        <= count_acc;
            first_rise_time   <= rise_acc;
            first_rise_seen   <= seen_acc;
            timeout_reference <= tref_acc;
            led_level         <= led_acc;
            now_sr            <= in_time;
            lim_sr            <= TB'(lim_full);
            brw_el            <= 1'b0;
            brw_du            <= 1'b0;
            gt                <= 1'b0;
            nz                <= 1'b0;
            bit_cnt           <= '0;
            r_active          <= meas_acc;
            r_done            <= 1'b0;
            r_tout            <= 1'b0;
            r_bpm             <= '0;
            state             <= meas_acc ? prm_pkg::S_SERIAL : prm_pkg::S_FINISH;
          end
        end
        prm_pkg::S_SERIAL: begin
          // Rotate the stored times so they are intact after the pass
          timeout_reference <= {timeout_reference[0], timeout_reference[TB-1:1]};
          first_rise_time   <= {first_rise_time[0], first_rise_time[TB-1:1]};
          now_sr            <= {du_bit, now_sr[TB-1:1]};
          lim_sr            <= {1'b0, lim_sr[TB-1:1]};
          brw_el            <= brw_el_next;
          brw_du            <= brw_du_next;
          gt                <= gt_next;
          nz                <= nz_next;
          bit_cnt           <= bit_cnt + 1'b1;
          if (bit_cnt == prm_pkg::CNT_BITS'(TB - 1)) begin
            if (gt_next) begin
              // Timeout wins over completion
              led_level <= 1'b0;
              measuring <= 1'b0;
              r_done    <= 1'b1;
              r_tout    <= 1'b1;
              state     <= prm_pkg::S_FINISH;
            end else if (beat_count >= beats_needed) begin
              measuring <= 1'b0;
              r_done    <= 1'b1;
              if (!nz_next) begin
                // Zero duration: full scale unless no beats were asked for
                r_bpm <= (beats_needed != '0) ? '1 : '0;
                state <= prm_pkg::S_FINISH;
              end else begin
                rem   <= num_full;
                dvs   <= {du_bit, now_sr[TB-1:1], prm_pkg::BPM_BITS'(0)};
                step  <= prm_pkg::STEP_BITS'(prm_pkg::BPM_BITS);
                state <= prm_pkg::S_DIVIDE;
              end
            end else begin
              state <= prm_pkg::S_FINISH;
            end
          end
        end
        prm_pkg::S_DIVIDE: begin
          // One restoring quotient bit per cycle, most significant first
          if (div_ge) begin
            rem <= rem - dvs[prm_pkg::NUM_BITS-1:0];
          end
          dvs  <= {1'b0, dvs[prm_pkg::D_BITS-1:1]};
          step <= step - 1'b1;
          if (step == prm_pkg::STEP_BITS'(prm_pkg::BPM_BITS)) begin
            quo <= '0;
            if (div_ge) begin
              // Quotient of 256 or more saturates
              r_bpm <= '1;
              state <= prm_pkg::S_FINISH;
            end
          end else begin
            quo <= {quo[prm_pkg::BPM_BITS-2:0], div_ge};
            if (step == '0) begin
              r_bpm <= {quo[prm_pkg::BPM_BITS-2:0], div_ge};
              state <= prm_pkg::S_FINISH;
            end
          end
        end
        prm_pkg::S_FINISH: begin
          // Hand the result to the output register once it is free
          if (!m_axis_tvalid || m_axis_tready) begin
            o_led         <= led_level && led_enable;
            o_active      <= r_active;
            o_done        <= r_done;
            o_tout        <= r_tout;
            o_bpm         <= r_bpm;
            m_axis_tvalid <= 1'b1;
            state         <= prm_pkg::S_IDLE;
          end
        end
        default: state <= prm_pkg::S_IDLE;
      endcase
    end
  end

  // Result packing
  assign m_axis_tdata = prm_pkg::OUT_TDATA_W'({o_bpm, o_tout, o_done, o_active, o_led});

`ifndef SYNTHESIS
  // A sample that neither starts nor continues a measurement skips the serial pass
  a_idle_skip: assert property (@(posedge clk) disable iff (rst)
    in_accept && !s_axis_tuser && !measuring |=> state == prm_pkg::S_FINISH)
    else $error("ignored sample entered the serial pass");

  // A timeout result always reports completion and a zero rate
  a_tout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_tout |-> o_done && o_bpm == '0)
    else $error("timeout result with nonzero rate or without done");

  // Completion is only reported for a sample inside a measurement
  a_done_active: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_done |-> o_active)
    else $error("done reported for an inactive sample");

  // The serial pass never runs past the timestamp width
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == prm_pkg::S_SERIAL |-> bit_cnt <= prm_pkg::CNT_BITS'(TB - 1))
    else $error("serial bit counter out of range");
`endif

endmodule
